@@ rtl/crc12tbc_pkg.sv @@
// Package with constants, sequencer states and coding functions for the CRC-12 tail-biting encoder.
`timescale 1ns / 1ps

package crc12tbc_pkg;

    localparam int PAYLOAD_BITS = 34;
    localparam int CRC_BITS     = 12;
    localparam int INFO_BITS    = PAYLOAD_BITS + CRC_BITS;
    localparam int STATE_BITS   = 9;
    localparam int REG_BITS     = STATE_BITS + 1;
    localparam int CNT_W        = $clog2(INFO_BITS);

    localparam logic [CRC_BITS-1:0] CRC_POLY = 12'h80F;
    localparam logic [REG_BITS-1:0] GEN_A    = 10'h277;
    localparam logic [REG_BITS-1:0] GEN_B    = 10'h365;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CRC,
        ST_ENC
    } seq_state_t;

    // One MSB-first CRC step for a single input bit
    function automatic logic [CRC_BITS-1:0] crc_step(input logic [CRC_BITS-1:0] crc,
                                                     input logic                bit_in);
        logic [CRC_BITS-1:0] mixed;
        mixed = crc ^ {bit_in, {(CRC_BITS-1){1'b0}}};
        if (mixed[CRC_BITS-1])
            return {mixed[CRC_BITS-2:0], 1'b0} ^ CRC_POLY;
        else
            return {mixed[CRC_BITS-2:0], 1'b0};
    endfunction

    // Map the two generator parities of a 10-bit window to a tone
    function automatic logic [1:0] tone_map(input logic [REG_BITS-1:0] window);
        logic b0;
        logic b1;
        b0 = ^(window & GEN_A);
        b1 = ^(window & GEN_B);
        return {b0, b0 ^ b1};
    endfunction

endpackage

@@ rtl/crc12_tailbiting_conv_encoder.sv @@
// Top level: bit-serial CRC-12 followed by a tail-biting rate-1/2 encoder with tone mapping.
// The first tone is registered in the encoding pass, after the CRC pass over all payload bits.
// The CRC takes one payload bit per cycle, then the encoder emits one tone per cycle
//   whenever the output register is free (out_valid low or out_stall low).
// The input channel is stalled from acceptance until the last tone has been registered.
// Reset clears the sequencer, counter and output valid; data registers are not reset.
`timescale 1ns / 1ps

module crc12_tailbiting_conv_encoder (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [crc12tbc_pkg::PAYLOAD_BITS-1:0] payload_word,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         tone_symbol,
    output logic                               last_tone
);
    import crc12tbc_pkg::*;

    seq_state_t              fsm_reg, fsm_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [PAYLOAD_BITS-1:0] shift_reg, shift_next;
    logic [CRC_BITS-1:0]     crc_reg, crc_next;
    logic [INFO_BITS-1:0]    info_reg, info_next;
    logic [STATE_BITS-1:0]   conv_reg, conv_next;
    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              tone_reg, tone_next;
    logic                    last_reg, last_next;

    logic                    in_take;
    logic                    out_free;
    logic [CRC_BITS-1:0]     crc_step_val;
    logic [REG_BITS-1:0]     window;

    assign in_stall    = (fsm_reg != ST_IDLE);
    assign in_take     = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign tone_symbol = tone_reg;
    assign last_tone   = last_reg;

    assign crc_step_val = crc_step(crc_reg, shift_reg[PAYLOAD_BITS-1]);
    assign window       = {conv_reg, info_reg[INFO_BITS-1]};

    // Hold the sequencer state, counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the data path
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        crc_reg   <= crc_next;
        info_reg  <= info_next;
        conv_reg  <= conv_next;
        tone_reg  <= tone_next;
        last_reg  <= last_next;
    end

    // Sequence the CRC pass and the encoding pass
    always_comb
    begin
        fsm_next       = fsm_reg;
        cnt_next       = cnt_reg;
        shift_next     = shift_reg;
        crc_next       = crc_reg;
        info_next      = info_reg;
        conv_next      = conv_reg;
        tone_next      = tone_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (fsm_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    shift_next = payload_word;
                    info_next  = {payload_word, {CRC_BITS{1'b0}}};
                    crc_next   = '0;
                    cnt_next   = '0;
                    fsm_next   = ST_CRC;
                end
            end
            ST_CRC:
            begin
                // Advance the CRC by one payload bit
                crc_next   = crc_step_val;
                shift_next = {shift_reg[PAYLOAD_BITS-2:0], 1'b0};
                if (cnt_reg == CNT_W'(PAYLOAD_BITS - 1))
                begin
                    info_next = {info_reg[INFO_BITS-1:CRC_BITS], crc_step_val};
                    conv_next = crc_step_val[STATE_BITS-1:0];
                    cnt_next  = '0;
                    fsm_next  = ST_ENC;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ENC:
            begin
                // Emit one tone whenever the output register can take it
                if (out_free)
                begin
                    tone_next      = tone_map(window);
                    last_next      = (cnt_reg == CNT_W'(INFO_BITS - 1));
                    out_valid_next = 1'b1;
                    conv_next      = window[STATE_BITS-1:0];
                    info_next      = {info_reg[INFO_BITS-2:0], 1'b0};
                    if (cnt_reg == CNT_W'(INFO_BITS - 1))
                    begin
                        cnt_next = '0;
                        fsm_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    // Checks on the sequencer
    a_take_starts_crc: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (fsm_reg == ST_CRC) && (cnt_reg == '0))
        else $error("accepted transaction did not start the CRC pass");

    a_crc_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == ST_CRC) |-> (cnt_reg < CNT_W'(PAYLOAD_BITS)))
        else $error("CRC bit counter out of range");

    a_enc_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == ST_ENC) |-> (cnt_reg < CNT_W'(INFO_BITS)))
        else $error("tone counter out of range");

    a_last_tone_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ((fsm_reg == ST_ENC) && out_free && (cnt_reg == CNT_W'(INFO_BITS - 1)))
        |=> (out_valid && last_tone && (fsm_reg == ST_IDLE)))
        else $error("final tone not flagged or frame not closed");

endmodule
